// ----- hw/rtl/ellras_pkg.sv -----
// Shared types for the ellipse rasterizer: opcodes, controller states and command/status bundles.
package ellras_pkg;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_REGION1,
      PH_REGION2
   } phase_type;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_SQX,
      ST_SQY,
      ST_PROD,
      ST_INIT,
      ST_ADJ,
      ST_R1_EVAL,
      ST_R1_DEC_A,
      ST_R1_DEC_B,
      ST_CROSS_A,
      ST_CROSS_B,
      ST_R2_EMIT,
      ST_R2_DEC_A,
      ST_R2_DEC_B
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_SQX,
      MUL_SQY,
      MUL_PROD
   } mul_op_type;

   typedef enum logic [3:0] {
      ARITH_NONE,
      ARITH_INIT,
      ARITH_ADJ,
      ARITH_R1_A,
      ARITH_R1_B,
      ARITH_R2_A,
      ARITH_R2_B,
      ARITH_CROSS_A,
      ARITH_CROSS_B
   } arith_op_type;

   typedef enum logic [1:0] {
      WALK_NONE,
      WALK_R1,
      WALK_R2
   } walk_op_type;

   typedef struct packed {
      logic         load;
      mul_op_type   mul_op;
      arith_op_type arith_op;
      walk_op_type  walk_op;
      logic         emit;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic dx_lt_dy;
      logic y_le_zero;
   } dp_status_type;

endpackage

// ----- hw/rtl/ellras_ctrl.sv -----
// Controller state machine that sequences setup, region walks and result handoff.
module ellras_ctrl
   import ellras_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_op,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == ST_WAIT);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cmd.load     = 1'b0;
      cmd.mul_op   = MUL_NONE;
      cmd.arith_op = ARITH_NONE;
      cmd.walk_op  = WALK_NONE;
      cmd.emit     = 1'b0;
      cmd.last     = 1'b0;
      case (state_ff)
         ST_WAIT: begin
            if (req_tvalid) begin
               if (op_type'(req_op) == OP_START) begin
                  cmd.load = 1'b1;
                  phase_in = PH_REGION1;
                  state_in = ST_SQX;
               end else begin
                  case (phase_ff)
                     PH_REGION1: state_in = ST_R1_EVAL;
                     PH_REGION2: state_in = ST_R2_EMIT;
                     default:    state_in = ST_WAIT;
                  endcase
               end
            end
         end
         ST_SQX: begin
            cmd.mul_op = MUL_SQX;
            state_in   = ST_SQY;
         end
         ST_SQY: begin
            cmd.mul_op = MUL_SQY;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.mul_op = MUL_PROD;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd.arith_op = ARITH_INIT;
            state_in     = ST_ADJ;
         end
         ST_ADJ: begin
            cmd.arith_op = ARITH_ADJ;
            state_in     = ST_WAIT;
         end
         ST_R1_EVAL: begin
            if (status.dx_lt_dy) begin
               if (out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.walk_op = WALK_R1;
                  state_in    = ST_R1_DEC_A;
               end
            end else begin
               state_in = ST_CROSS_A;
            end
         end
         ST_R1_DEC_A: begin
            cmd.arith_op = ARITH_R1_A;
            state_in     = ST_R1_DEC_B;
         end
         ST_R1_DEC_B: begin
            cmd.arith_op = ARITH_R1_B;
            state_in     = ST_WAIT;
         end
         ST_CROSS_A: begin
            cmd.arith_op = ARITH_CROSS_A;
            state_in     = ST_CROSS_B;
         end
         ST_CROSS_B: begin
            cmd.arith_op = ARITH_CROSS_B;
            phase_in     = PH_REGION2;
            state_in     = ST_R2_EMIT;
         end
         ST_R2_EMIT: begin
            if (out_free) begin
               cmd.emit    = 1'b1;
               cmd.last    = status.y_le_zero;
               cmd.walk_op = WALK_R2;
               if (status.y_le_zero) begin
                  phase_in = PH_IDLE;
               end
               state_in = ST_R2_DEC_A;
            end
         end
         ST_R2_DEC_A: begin
            cmd.arith_op = ARITH_R2_A;
            state_in     = ST_R2_DEC_B;
         end
         ST_R2_DEC_B: begin
            cmd.arith_op = ARITH_R2_B;
            state_in     = ST_WAIT;
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ----- hw/rtl/ellras_dpath.sv -----
// Datapath holding the ellipse terms, the shared multiplier, the decision adder and the result register.
module ellras_dpath
   import ellras_pkg::*;
#(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 10
) (
   input  logic                    clock,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic [COORD_BITS-1:0]   center_x,
   input  logic [COORD_BITS-1:0]   center_y,
   input  logic [RADIUS_BITS-1:0]  radius_x,
   input  logic [RADIUS_BITS-1:0]  radius_y,
   input  logic [7:0]              ink,
   output logic [COORD_BITS+1:0]   left_x,
   output logic [COORD_BITS+1:0]   right_x,
   output logic [COORD_BITS+1:0]   upper_y,
   output logic [COORD_BITS+1:0]   lower_y,
   output logic [7:0]              ink_out,
   output logic                    last
);

   localparam int SQ_W   = 2 * RADIUS_BITS;
   localparam int PROD_W = 3 * RADIUS_BITS;
   localparam int DEC_W  = 3 * RADIUS_BITS + 5;
   localparam int OFF_W  = RADIUS_BITS + 2;
   localparam int OUT_W  = COORD_BITS + 2;
   localparam int CALC_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 3;

   logic [COORD_BITS-1:0]  cx_ff, cy_ff;
   logic [RADIUS_BITS-1:0] rx_ff, ry_ff;
   logic [7:0]             ink_ff;
   logic [SQ_W-1:0]        rxsq_ff, rysq_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [PROD_W-1:0]      mul_res;
   logic [SQ_W-1:0]        mul_a;
   logic [RADIUS_BITS-1:0] mul_b;

   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic signed [DEC_W-1:0] dx_ff, dx_in;
   logic signed [DEC_W-1:0] dy_ff, dy_in;
   logic signed [DEC_W-1:0] tmp_ff, tmp_in;
   logic signed [DEC_W-1:0] adj_ff, adj_in;
   logic signed [OFF_W-1:0] ox_ff, ox_in;
   logic signed [OFF_W-1:0] oy_ff, oy_in;
   logic                    flag_ff, flag_in;

   logic signed [DEC_W-1:0] rxsq_ext, rysq_ext, prod_ext;
   logic signed [DEC_W-1:0] triple, rounded;

   logic [OUT_W-1:0] left_ff, right_ff, upper_ff, lower_ff;
   logic [7:0]       ink_out_ff;
   logic             last_ff;
   logic signed [CALC_W-1:0] cx_ext, cy_ext, ox_ext, oy_ext;
   logic signed [CALC_W-1:0] left_c, right_c, upper_c, lower_c;

   assign rxsq_ext = $signed(DEC_W'(rxsq_ff));
   assign rysq_ext = $signed(DEC_W'(rysq_ff));
   assign prod_ext = $signed(DEC_W'(prod_ff));

   always_comb begin
      case (cmd.mul_op)
         MUL_SQX: begin
            mul_a = SQ_W'(rx_ff);
            mul_b = rx_ff;
         end
         MUL_SQY: begin
            mul_a = SQ_W'(ry_ff);
            mul_b = ry_ff;
         end
         MUL_PROD: begin
            mul_a = rxsq_ff;
            mul_b = ry_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      decision_in = decision_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      tmp_in      = tmp_ff;
      adj_in      = adj_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      flag_in     = flag_ff;
      triple      = (tmp_ff <<< 1) + tmp_ff;
      rounded     = '0;
      case (cmd.arith_op)
         ARITH_INIT: begin
            decision_in = rysq_ext - prod_ext + (rxsq_ext >>> 2);
            dx_in       = '0;
            dy_in       = prod_ext <<< 1;
            ox_in       = '0;
            oy_in       = $signed(OFF_W'(ry_ff));
            tmp_in      = rxsq_ext - rysq_ext;
         end
         ARITH_ADJ: begin
            rounded = triple + $signed(DEC_W'(triple[DEC_W-1]));
            adj_in  = rounded >>> 1;
         end
         ARITH_R1_A: begin
            decision_in = decision_ff + dx_ff - (flag_ff ? dy_ff : '0);
         end
         ARITH_R1_B: begin
            decision_in = decision_ff + rysq_ext;
         end
         ARITH_R2_A: begin
            decision_in = decision_ff + (flag_ff ? dx_ff : '0) - dy_ff;
         end
         ARITH_R2_B: begin
            decision_in = decision_ff + rxsq_ext;
         end
         ARITH_CROSS_A: begin
            tmp_in = adj_ff - dx_ff - dy_ff;
         end
         ARITH_CROSS_B: begin
            rounded     = tmp_ff + $signed(DEC_W'(tmp_ff[DEC_W-1]));
            decision_in = decision_ff + (rounded >>> 1);
         end
         default: begin
         end
      endcase
      case (cmd.walk_op)
         WALK_R1: begin
            flag_in = (decision_ff > 0);
            ox_in   = ox_ff + OFF_W'(1);
            dx_in   = dx_ff + (rysq_ext <<< 1);
            if (decision_ff > 0) begin
               oy_in = oy_ff - OFF_W'(1);
               dy_in = dy_ff - (rxsq_ext <<< 1);
            end
         end
         WALK_R2: begin
            flag_in = (decision_ff < 0);
            oy_in   = oy_ff - OFF_W'(1);
            dy_in   = dy_ff - (rxsq_ext <<< 1);
            if (decision_ff < 0) begin
               ox_in = ox_ff + OFF_W'(1);
               dx_in = dx_ff + (rysq_ext <<< 1);
            end
         end
         default: begin
         end
      endcase
   end

   assign cx_ext  = $signed(CALC_W'(cx_ff));
   assign cy_ext  = $signed(CALC_W'(cy_ff));
   assign ox_ext  = CALC_W'(ox_ff);
   assign oy_ext  = CALC_W'(oy_ff);
   assign left_c  = cx_ext - ox_ext;
   assign right_c = cx_ext + ox_ext;
   assign upper_c = cy_ext - oy_ext;
   assign lower_c = cy_ext + oy_ext;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff  <= center_x;
         cy_ff  <= center_y;
         rx_ff  <= radius_x;
         ry_ff  <= radius_y;
         ink_ff <= ink;
      end
      case (cmd.mul_op)
         MUL_SQX:  rxsq_ff <= mul_res[SQ_W-1:0];
         MUL_SQY:  rysq_ff <= mul_res[SQ_W-1:0];
         MUL_PROD: prod_ff <= mul_res;
         default: begin
         end
      endcase
      decision_ff <= decision_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      tmp_ff      <= tmp_in;
      adj_ff      <= adj_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      flag_ff     <= flag_in;
      if (cmd.emit) begin
         left_ff    <= left_c[OUT_W-1:0];
         right_ff   <= right_c[OUT_W-1:0];
         upper_ff   <= upper_c[OUT_W-1:0];
         lower_ff   <= lower_c[OUT_W-1:0];
         ink_out_ff <= ink_ff;
         last_ff    <= cmd.last;
      end
   end

   assign status.dx_lt_dy  = (dx_ff < dy_ff);
   assign status.y_le_zero = oy_ff[OFF_W-1] || (oy_ff == '0);

   assign left_x  = left_ff;
   assign right_x = right_ff;
   assign upper_y = upper_ff;
   assign lower_y = lower_ff;
   assign ink_out = ink_out_ff;
   assign last    = last_ff;

endmodule

// ----- hw/rtl/ellipse_rasterizer.sv -----
// Top level of the midpoint ellipse rasterizer: stream ports, controller and datapath.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: operation; tdata: center_x, center_y, radius_x, radius_y, ink
//   rsp_     out        tdata: left_x, right_x, upper_y, lower_y, ink_out; tlast: last
//
// A start beat holds the input for three passes through the shared multiplier, then the
// setup of the decision terms in ST_INIT and ST_ADJ. A step beat updates the decision term
// in its region's DEC_A and DEC_B states, after CROSS_A, CROSS_B and R2_EMIT on crossover.
// A step beat while idle is dropped in its accept cycle.
// Reset is synchronous and leaves the block idle with no ellipse loaded.
// A step waits before its emit cycle while an earlier result has not been taken.
module ellipse_rasterizer
   import ellras_pkg::*;
#(
   parameter int COORD_BITS  = 10,
   parameter int RADIUS_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: center_x, center_y, radius_x, radius_y, ink, zero fill.
   input  logic [((2*COORD_BITS+2*RADIUS_BITS+8+7)/8)*8-1:0] req_tdata,
   // Fields from bit 0: operation.
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: left_x, right_x, upper_y, lower_y, ink_out, zero fill.
   output logic [((4*(COORD_BITS+2)+8+7)/8)*8-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int OUT_W      = COORD_BITS + 2;
   localparam int RSP_DATA_W = ((4 * OUT_W + 8 + 7) / 8) * 8;
   localparam int CY_LO      = COORD_BITS;
   localparam int RX_LO      = 2 * COORD_BITS;
   localparam int RY_LO      = 2 * COORD_BITS + RADIUS_BITS;
   localparam int INK_LO     = 2 * COORD_BITS + 2 * RADIUS_BITS;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [OUT_W-1:0] left_x, right_x, upper_y, lower_y;
   logic [7:0]       ink_out;

   ellras_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ellras_dpath #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .status   (status),
      .center_x (req_tdata[COORD_BITS-1:0]),
      .center_y (req_tdata[CY_LO +: COORD_BITS]),
      .radius_x (req_tdata[RX_LO +: RADIUS_BITS]),
      .radius_y (req_tdata[RY_LO +: RADIUS_BITS]),
      .ink      (req_tdata[INK_LO +: 8]),
      .left_x   (left_x),
      .right_x  (right_x),
      .upper_y  (upper_y),
      .lower_y  (lower_y),
      .ink_out  (ink_out),
      .last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({ink_out, lower_y, upper_y, right_x, left_x});

endmodule
